// ===== design/sib_pkg.sv =====
// sib_pkg: shared types and codes for the sorted insert buffer
// used by the interfaces, the store, the sequencer and the top level
// no dependencies

package sib_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_DRAINED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [1:0]                t_status;

    typedef struct packed {
        t_status status;
        t_value  out_value;
        logic    last;
    } t_result;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

// ===== design/sib_if.sv =====
// sib_in_if and sib_out_if: valid/ready channels of the sorted insert buffer
// depends on sib_pkg

interface sib_in_if;
    logic            valid;
    logic            ready;
    logic            action;
    sib_pkg::t_value value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface sib_out_if;
    logic             valid;
    logic             ready;
    sib_pkg::t_status status;
    sib_pkg::t_value  out_value;
    logic             last;

    modport source (output valid, output status, output out_value, output last, input ready);
    modport sink   (input valid, input status, input out_value, input last, output ready);
endinterface

// ===== design/sorted_insert_buffer_top.sv =====
// sorted_insert_buffer_top: bounded ascending store of signed 32-bit values
// depends on sib_pkg, sib_in_if/sib_out_if, sib_store and sib_seq
//
// usage
//   i_in carries items of {action, value}: action insert places value after
//   every stored value less than or equal to it; action drain streams out the
//   whole store in ascending order and empties it
//   o_out carries results of {status, out_value, last}: one result per insert
//   (accepted, or dropped when the store holds CAPACITY values), one drained
//   value per stored entry on drain with last on the final one, or a single
//   empty result when draining an empty store
//   an insert into a non-empty store moves each larger stored entry up one
//   place, walking down from the top one step per cycle with the shared
//   compare over the store's single read port; an insert into an empty
//   store, a dropped insert or a drain of an empty store needs no walk; a
//   drain of n entries streams them out with one registered memory read per
//   value
//   i_in.ready is high only while the sequencer is idle; an output register
//   decouples the result side, so a new item can be taken while the last
//   result still waits
//   reset clears the entry count and all control state; the store contents
//   are left as they are and only entries below the count are ever read
//   when the receiver stalls, the output register holds its result and the
//   sequencer waits with the next one, nothing is lost or repeated

module sorted_insert_buffer_top #(
    parameter int CAPACITY = sib_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sib_in_if.sink    i_in,
    sib_out_if.source o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // sequencer to output register
    logic              w_res_valid;
    logic              w_res_ready;
    sib_pkg::t_result  w_res;

    // sequencer to store
    sib_pkg::t_mem_ctl w_mem_ctl;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    sib_pkg::t_value   w_wdata;
    sib_pkg::t_value   w_rdata;

    // output register
    logic              r_out_valid;
    sib_pkg::t_result  r_out;

    sib_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_ctl   (w_mem_ctl),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    sib_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // register takes a new result when empty or being emptied this cycle
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out.status;
    assign o_out.out_value = r_out.out_value;
    assign o_out.last      = r_out.last;

endmodule

// ===== design/sib_store.sv =====
// sib_store: value memory, one write and one registered read port
// depends on sib_pkg

module sib_store #(
    parameter int DEPTH = sib_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  sib_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_waddr,
    input  sib_pkg::t_value   i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output sib_pkg::t_value   o_rdata
);

    sib_pkg::t_value r_mem [DEPTH];
    sib_pkg::t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sib_seq.sv =====
// sib_seq: sequencer that walks the store with one shared compare
// insert shifts larger entries up one place per step, drain reads out in order
// depends on sib_pkg and sib_in_if

module sib_seq #(
    parameter int CAPACITY = sib_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sib_in_if.sink            i_in,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output sib_pkg::t_result  o_res,
    output sib_pkg::t_mem_ctl o_mem_ctl,
    output logic [AW-1:0]     o_waddr,
    output sib_pkg::t_value   o_wdata,
    output logic [AW-1:0]     o_raddr,
    input  sib_pkg::t_value   i_rdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    sib_pkg::t_value  r_value, n_value;
    sib_pkg::t_status r_status, n_status;

    logic [CW-1:0] w_waddr, w_raddr;
    logic          w_le;
    logic          w_last;

    // the shared compare: stored entry <= new value
    assign w_le   = (i_rdata <= r_value);
    assign w_last = (r_idx == r_count - CW'(1));

    assign i_in.ready = (r_state == S_IDLE);
    assign o_waddr    = w_waddr[AW-1:0];
    assign o_raddr    = w_raddr[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_value     = r_value;
        n_status    = r_status;
        o_mem_ctl   = '0;
        w_waddr     = '0;
        w_raddr     = '0;
        o_wdata     = r_value;
        o_res_valid = 1'b0;
        o_res       = '{status: r_status, out_value: '0, last: 1'b1};
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_value = i_in.value;
                    if (i_in.action == sib_pkg::ACT_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = sib_pkg::ST_DROPPED;
                            n_state  = S_RESP;
                        end else if (r_count == '0) begin
                            o_mem_ctl.we = 1'b1;
                            o_wdata      = i_in.value;
                            n_count      = CW'(1);
                            n_status     = sib_pkg::ST_ACCEPTED;
                            n_state      = S_RESP;
                        end else begin
                            o_mem_ctl.re = 1'b1;
                            w_raddr      = r_count - CW'(1);
                            n_idx        = r_count;
                            n_state      = S_INS;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = sib_pkg::ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            o_mem_ctl.re = 1'b1;
                            n_idx        = '0;
                            n_state      = S_DRAIN;
                        end
                    end
                end
            end
            S_INS: begin
                o_mem_ctl.we = 1'b1;
                w_waddr      = r_idx;
                if (w_le) begin
                    n_count  = r_count + CW'(1);
                    n_status = sib_pkg::ST_ACCEPTED;
                    n_state  = S_RESP;
                end else begin
                    // move the larger entry up one place
                    o_wdata = i_rdata;
                    n_idx   = r_idx - CW'(1);
                    if (r_idx == CW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        o_mem_ctl.re = 1'b1;
                        w_raddr      = r_idx - CW'(2);
                    end
                end
            end
            S_PUT: begin
                o_mem_ctl.we = 1'b1;
                n_count      = r_count + CW'(1);
                n_status     = sib_pkg::ST_ACCEPTED;
                n_state      = S_RESP;
            end
            S_DRAIN: begin
                o_res_valid = 1'b1;
                o_res       = '{status: sib_pkg::ST_DRAINED, out_value: i_rdata, last: w_last};
                if (i_res_ready) begin
                    if (w_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        // read data holds while stalled, next read only on hand-off
                        o_mem_ctl.re = 1'b1;
                        n_idx        = r_idx + CW'(1);
                        w_raddr      = r_idx + CW'(1);
                    end
                end
            end
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_value  <= n_value;
        r_status <= n_status;
    end

endmodule
